>>> hw/rtl/tet_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types, codes and sizes for the titled entry table.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int MAX_ENTRIES  = 32;
  localparam int TITLE_BYTES  = 6;
  localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
  localparam logic [19:0] LENGTH_LIMIT = 20'd1048560;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EXISTS    = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] title;
    logic [2:0]  title_len;
    logic [15:0] start_page;
    logic [19:0] chapter_length;
    logic [31:0] hash_value;
  } tet_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] found_title;
    logic [15:0] found_start;
    logic [19:0] found_length;
    logic [31:0] found_hash;
    logic [4:0]  found_position;
    logic [5:0]  entry_count;
  } tet_out_t;

  typedef struct packed {
    logic [47:0] title;
    logic [15:0] start;
    logic [19:0] length;
    logic [31:0] hash;
  } tet_entry_t;

  // Controls shared by every cell of the row.
  typedef struct packed {
    logic        cmp_en;
    logic [47:0] key;
    logic [47:0] mask;
    tet_entry_t  wr_data;
  } tet_cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/tet_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tet_cell
// One table slot: holds an entry, compares its title prefix with the key,
// loads a new entry or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module tet_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tet_pkg::tet_cell_ctl_t ctl,
  input  wire                    occ,
  input  wire                    wr_en,
  input  wire                    shift_en,
  input  tet_pkg::tet_entry_t    nbr_entry,
  output tet_pkg::tet_entry_t    entry,
  output logic                   match
);
  import tet_pkg::*;

  tet_entry_t entry_r;
  logic       match_r;

  // Entry payload: write wins over shift.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= ctl.wr_data;
    end else if (shift_en) begin
      entry_r <= nbr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      match_r <= occ && ((entry_r.title & ctl.mask) == ctl.key);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule
`default_nettype wire

>>> hw/rtl/titled_entry_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// titled_entry_table
// Ordered table of titled entries with prefix lookup, add, modify, delete.
// ----------------------------------------------------------------------------
// The table is a row of MAX_ENTRIES cells; cell i holds entry i, and cells
// below the entry count are in use. One request word is taken at a time.
// Every cell compares its title prefix with the key in one registered step,
// and the first match in table order is picked from the registered match
// bits. Lookup, add, modify and a bad title length go from acceptance to the
// result word through the accept, compare, execute and deliver steps. Delete
// removes one matching entry per pass by shifting every cell at or above the
// first match down by one, then compares again, until no match is left.
// The result sits in an output register; the next request is taken as soon
// as the block is back in idle, even while that result word waits for the
// consumer. A result word is only loaded once the output register is free.
// Titles are stored with bytes at and beyond title_len cleared, and lengths
// above the limit are saturated on store.
// ----------------------------------------------------------------------------
module titled_entry_table (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  tet_pkg::tet_in_t in_word,
  output logic             out_valid,
  input  wire              out_stall,
  output tet_pkg::tet_out_t out_word
);
  import tet_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CMP, S_EXEC, S_DEL_CMP, S_DEL_CHK, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  tet_in_t       req_r, req_nxt;
  logic [47:0]   key_r, key_nxt;
  logic [47:0]   mask_r, mask_nxt;
  tet_out_t      res_r, res_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  tet_out_t      out_word_r, out_word_nxt;

  tet_cell_ctl_t           ctl;
  logic                    cmp_en;
  tet_entry_t              cell_entry [MAX_ENTRIES];
  tet_entry_t              cell_nbr   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  match_vec;
  logic [MAX_ENTRIES-1:0]  occ_vec;
  logic [MAX_ENTRIES-1:0]  wr_vec;
  logic [MAX_ENTRIES-1:0]  shift_vec;
  logic [MAX_ENTRIES-1:0]  first_vec;
  logic [MAX_ENTRIES-1:0]  upper_vec;
  logic                    hit;
  tet_entry_t              found;
  logic [4:0]              found_pos;
  logic [MAX_ENTRIES-1:0]  add_sel;
  logic                    bad_len;
  logic                    full;
  logic                    out_free;
  logic [47:0]             in_mask;
  logic [19:0]             sat_len;

  // ---- cell row -----------------------------------------------------------
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign cell_nbr[i] = '0;
    end else begin : g_mid
      assign cell_nbr[i] = cell_entry[i+1];
    end
    assign occ_vec[i] = (CNT_W'(i) < count_r);
    assign add_sel[i] = (CNT_W'(i) == count_r);

    tet_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .occ       (occ_vec[i]),
      .wr_en     (wr_vec[i]),
      .shift_en  (shift_vec[i]),
      .nbr_entry (cell_nbr[i]),
      .entry     (cell_entry[i]),
      .match     (match_vec[i])
    );
  end

  // ---- first match pick ---------------------------------------------------
  // Isolate the lowest set match bit; everything at or above it moves down.
  assign first_vec = match_vec & (~match_vec + MAX_ENTRIES'(1));
  assign hit       = |match_vec;
  assign upper_vec = hit ? ~(first_vec - MAX_ENTRIES'(1)) : '0;

  always_comb begin
    found     = '0;
    found_pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (first_vec[i]) begin
        found     = found | cell_entry[i];
        found_pos = found_pos | 5'(i);
      end
    end
  end

  // ---- request decode -----------------------------------------------------
  always_comb begin
    for (int b = 0; b < TITLE_BYTES; b++) begin
      in_mask[8*b +: 8] = {8{3'(b) < in_word.title_len}};
    end
  end

  assign bad_len  = (req_r.title_len == 3'd0) || (req_r.title_len > 3'(TITLE_BYTES));
  assign full     = (count_r == CNT_W'(MAX_ENTRIES));
  assign out_free = !out_valid_r || !out_stall;
  assign sat_len  = (req_r.chapter_length > LENGTH_LIMIT) ? LENGTH_LIMIT
                                                          : req_r.chapter_length;

  assign ctl.cmp_en          = cmp_en;
  assign ctl.key             = key_r;
  assign ctl.mask            = mask_r;
  assign ctl.wr_data.title   = key_r;
  assign ctl.wr_data.start   = req_r.start_page;
  assign ctl.wr_data.length  = sat_len;
  assign ctl.wr_data.hash    = req_r.hash_value;

  assign in_stall = (state_r != S_IDLE);

  // ---- sequencer ----------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    mask_nxt      = mask_r;
    res_nxt       = res_r;
    count_nxt     = count_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmp_en        = 1'b0;
    wr_vec        = '0;
    shift_vec     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_word;
          mask_nxt  = in_mask;
          key_nxt   = in_word.title & in_mask;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmp_en    = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_nxt = '0;
        if (bad_len) begin
          res_nxt.status = ST_BAD_LEN;
          state_nxt      = S_DONE;
        end else begin
          if (hit) begin
            res_nxt.found_title    = found.title;
            res_nxt.found_start    = found.start;
            res_nxt.found_length   = found.length;
            res_nxt.found_hash     = found.hash;
            res_nxt.found_position = found_pos;
          end
          state_nxt = S_DONE;
          case (req_r.opcode)
            OP_LOOKUP: begin
              res_nxt.status = hit ? ST_OK : ST_NOT_FOUND;
            end
            OP_ADD: begin
              if (hit) begin
                res_nxt.status = ST_EXISTS;
              end else if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_vec         = add_sel;
                count_nxt      = count_r + CNT_W'(1);
                res_nxt.status = ST_OK;
              end
            end
            OP_MODIFY: begin
              if (hit) begin
                wr_vec         = first_vec;
                res_nxt.status = ST_OK;
              end else begin
                res_nxt.status = ST_NOT_FOUND;
              end
            end
            OP_DELETE: begin
              if (hit) begin
                shift_vec      = upper_vec;
                count_nxt      = count_r - CNT_W'(1);
                res_nxt.status = ST_OK;
                state_nxt      = S_DEL_CMP;
              end else begin
                res_nxt.status = ST_NOT_FOUND;
              end
            end
            default: begin
              res_nxt.status = ST_NOT_FOUND;
            end
          endcase
        end
      end
      S_DEL_CMP: begin
        // Refresh match bits after the last shift.
        cmp_en    = 1'b1;
        state_nxt = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (hit) begin
          shift_vec = upper_vec;
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DEL_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          out_word_nxt             = res_r;
          out_word_nxt.entry_count = 6'(count_r);
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    mask_r     <= mask_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---- checks -------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_accept_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CMP))
    else $error("accepted word did not start a compare");

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(first_vec))
    else $error("first match pick not one-hot");

  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_CHK && hit) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete pass did not drop one entry");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.status <= ST_FULL))
    else $error("result status code out of range");

endmodule
`default_nettype wire
